[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define HBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define HBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HBC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/hbc_pkg.sv]
// ----------------------------------------------------------------------------
// hbc_pkg
// shared types and constants of the hashed block buffer cache
// ----------------------------------------------------------------------------
`default_nettype none

package hbc_pkg;

   // default geometry
   localparam int DefNumBuffers = 30;
   localparam int DefNumBuckets = 13;

   // fixed field widths
   localparam int FUNC_W   = 2;
   localparam int DEV_W    = 8;
   localparam int BLOCK_W  = 32;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 8;
   localparam int BITCNT_W = 3;

   localparam logic [CNT_W-1:0] CntMax = 8'd255;

   // request operations
   typedef enum logic [FUNC_W-1:0] {
      FUNC_GET     = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_PIN     = 2'd2,
      FUNC_UNPIN   = 2'd3
   } func_type;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MOD,
      OP_WALK_HEAD,
      OP_WALK_NEXT,
      OP_FREE_HEAD,
      OP_FREE_PREV,
      OP_OWN,
      OP_SCAN_INIT,
      OP_SCAN_NEXT,
      OP_HIT,
      OP_FILL_OWN,
      OP_FILL_STEAL,
      OP_NOFREE,
      OP_SLOT,
      OP_DET_RD,
      OP_DET_WR,
      OP_PUSH_RD,
      OP_PUSH_WR1,
      OP_PUSH_WR2,
      OP_EMIT
   } hbc_op_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD,
      S_WALK_START,
      S_WALK,
      S_FREE_START,
      S_FREE,
      S_SCAN,
      S_SLOT,
      S_DET_RD,
      S_DET_WR,
      S_PUSH_RD,
      S_PUSH_WR1,
      S_PUSH_WR2,
      S_DONE
   } hbc_state_type;

   typedef struct packed {
      hbc_op_type op;
   } hbc_cmd_type;

   typedef struct packed {
      logic mod_last;
      logic walk_end;
      logic match;
      logic cnt_zero;
      logic own_phase;
      logic scan_done;
      logic scan_is_id;
      logic relink;
      logic out_free;
   } hbc_stat_type;

endpackage

`default_nettype wire

[rtl/hbc_ctrl.sv]
// ----------------------------------------------------------------------------
// hbc_ctrl
// sequencer of the buffer cache: walks, steals, relinks and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module hbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [hbc_pkg::FUNC_W-1:0] req_func,
   output logic                  req_stall,
   input  hbc_pkg::hbc_stat_type stat,
   output hbc_pkg::hbc_cmd_type  cmd
);
   import hbc_pkg::*;

   hbc_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = (req_func == FUNC_GET) ? S_MOD : S_SLOT;
         end
         S_MOD: begin
            if (stat.mod_last) state_in = S_WALK_START;
         end
         S_WALK_START: state_in = S_WALK;
         S_WALK: begin
            if (stat.walk_end) state_in = S_FREE_START;
            else if (stat.match) state_in = S_DONE;
         end
         S_FREE_START: state_in = S_FREE;
         S_FREE: begin
            if (stat.walk_end) state_in = S_SCAN;
            else if (stat.cnt_zero) state_in = stat.own_phase ? S_DONE : S_DET_RD;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_DONE;
            else if (!stat.scan_is_id) state_in = S_FREE;
         end
         S_SLOT:     state_in = stat.relink ? S_DET_RD : S_DONE;
         S_DET_RD:   state_in = S_DET_WR;
         S_DET_WR:   state_in = S_PUSH_RD;
         S_PUSH_RD:  state_in = S_PUSH_WR1;
         S_PUSH_WR1: state_in = S_PUSH_WR2;
         S_PUSH_WR2: state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath command
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_MOD:        cmd.op = OP_MOD;
         S_WALK_START: cmd.op = OP_WALK_HEAD;
         S_WALK: begin
            if (stat.walk_end) cmd.op = OP_OWN;
            else if (stat.match) cmd.op = OP_HIT;
            else cmd.op = OP_WALK_NEXT;
         end
         S_FREE_START: cmd.op = OP_FREE_HEAD;
         S_FREE: begin
            if (stat.walk_end) cmd.op = stat.own_phase ? OP_SCAN_INIT : OP_SCAN_NEXT;
            else if (stat.cnt_zero) cmd.op = stat.own_phase ? OP_FILL_OWN : OP_FILL_STEAL;
            else cmd.op = OP_FREE_PREV;
         end
         S_SCAN: begin
            if (stat.scan_done) cmd.op = OP_NOFREE;
            else if (stat.scan_is_id) cmd.op = OP_SCAN_NEXT;
            else cmd.op = OP_FREE_HEAD;
         end
         S_SLOT:     cmd.op = OP_SLOT;
         S_DET_RD:   cmd.op = OP_DET_RD;
         S_DET_WR:   cmd.op = OP_DET_WR;
         S_PUSH_RD:  cmd.op = OP_PUSH_RD;
         S_PUSH_WR1: cmd.op = OP_PUSH_WR1;
         S_PUSH_WR2: cmd.op = OP_PUSH_WR2;
         S_DONE: begin
            if (stat.out_free) cmd.op = OP_EMIT;
         end
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

[rtl/hbc_dp.sv]
// ----------------------------------------------------------------------------
// hbc_dp
// datapath: buffer tags and counts, bucket link memories, hash and result
// ----------------------------------------------------------------------------
`default_nettype none

module hbc_dp #(
   parameter int NumBuffers = hbc_pkg::DefNumBuffers,
   parameter int NumBuckets = hbc_pkg::DefNumBuckets
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hbc_pkg::hbc_cmd_type         cmd,
   output hbc_pkg::hbc_stat_type        stat,
   input  logic [hbc_pkg::FUNC_W-1:0]   req_func,
   input  logic [hbc_pkg::DEV_W-1:0]    req_device,
   input  logic [hbc_pkg::BLOCK_W-1:0]  req_block_number,
   input  logic [hbc_pkg::SLOT_W-1:0]   req_buffer_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hbc_pkg::SLOT_W-1:0]   rsp_granted_slot,
   output logic                         rsp_hit,
   output logic                         rsp_needs_read,
   output logic [hbc_pkg::STATUS_W-1:0] rsp_status
);
   import hbc_pkg::*;

   localparam int NodeCount = NumBuffers + NumBuckets;
   localparam int NODE_W    = $clog2(NodeCount);
   localparam int BUF_W     = (NumBuffers > 1) ? $clog2(NumBuffers) : 1;
   localparam int BKT_W     = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int FB_W      = BKT_W + 1;
   localparam int NIB_IDX_W = BKT_W + 4;

   localparam logic [NODE_W-1:0] BufBase = NODE_W'(NumBuffers);

   // list layout after reset
   logic [NODE_W-1:0] init_next [NodeCount];
   logic [NODE_W-1:0] init_prev [NodeCount];
   logic [BKT_W-1:0]  own_init  [NumBuffers];

   for (genvar g = 0; g < NumBuffers; g++) begin : g_buf_init
      localparam int Bkt  = g % NumBuckets;
      localparam int Next = (g >= NumBuckets) ? g - NumBuckets : NumBuffers + Bkt;
      localparam int Prev = (g + NumBuckets < NumBuffers) ? g + NumBuckets
                                                          : NumBuffers + Bkt;
      assign init_next[g] = NODE_W'(Next);
      assign init_prev[g] = NODE_W'(Prev);
      assign own_init[g]  = BKT_W'(Bkt);
   end

   for (genvar k = 0; k < NumBuckets; k++) begin : g_head_init
      localparam int Last = k + NumBuckets * ((NumBuffers - 1 - k) / NumBuckets);
      localparam int Next = (k < NumBuffers) ? Last : NumBuffers + k;
      localparam int Prev = (k < NumBuffers) ? k : NumBuffers + k;
      assign init_next[NumBuffers + k] = NODE_W'(Next);
      assign init_prev[NumBuffers + k] = NODE_W'(Prev);
   end

   // remainder table for one nibble step of the bucket hash
   logic [BKT_W-1:0] mod_tab [2**NIB_IDX_W];

   for (genvar g = 0; g < 2**NIB_IDX_W; g++) begin : g_mod_tab
      assign mod_tab[g] = BKT_W'(g % NumBuckets);
   end

   // request and working registers
   func_type             func_ff;
   logic [DEV_W-1:0]     dev_ff;
   logic [BLOCK_W-1:0]   blk_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [BLOCK_W-1:0]   shreg_ff;
   logic [BITCNT_W-1:0]  bitcnt_ff;
   logic [BKT_W-1:0]     id_ff;
   logic [FB_W-1:0]      fb_ff;
   logic                 own_ff;
   logic                 dir_ff;
   logic [NODE_W-1:0]    steps_ff;
   logic [NODE_W-1:0]    tgt_ff;
   logic [BKT_W-1:0]     dst_ff;
   logic [NODE_W-1:0]    first_ff;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic                 res_hit_ff;
   logic                 res_nread_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_nread_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   // per-buffer state
   logic [DEV_W-1:0]   dev_arr_ff [NumBuffers];
   logic [BLOCK_W-1:0] blk_arr_ff [NumBuffers];
   logic               val_arr_ff [NumBuffers];
   logic [CNT_W-1:0]   cnt_arr_ff [NumBuffers];
   logic [BKT_W-1:0]   own_arr_ff [NumBuffers];

   // link memories with written-once flags
   logic [NODE_W-1:0] next_mem [NodeCount];
   logic [NODE_W-1:0] prev_mem [NodeCount];
   logic              nv_ff    [NodeCount];
   logic              pv_ff    [NodeCount];
   logic [NODE_W-1:0] next_q_ff, prev_q_ff, next_a_ff, prev_a_ff;
   logic              next_v_ff, prev_v_ff;

   // link read data, untouched entries read as the reset layout
   logic [NODE_W-1:0] next_rd, prev_rd, node, head;
   logic [BUF_W-1:0]  node_idx, slot_idx, cnt_addr;
   logic [BKT_W-1:0]  cur_bkt, slot_bkt;
   logic [CNT_W-1:0]  cnt_cur;
   logic              slot_bad;
   logic [BKT_W-1:0]  mod_next;

   assign next_rd  = next_v_ff ? next_q_ff : init_next[next_a_ff];
   assign prev_rd  = prev_v_ff ? prev_q_ff : init_prev[prev_a_ff];
   assign node     = dir_ff ? prev_rd : next_rd;
   assign node_idx = node[BUF_W-1:0];
   assign slot_idx = BUF_W'(slot_ff);
   assign cur_bkt  = dir_ff ? fb_ff[BKT_W-1:0] : id_ff;
   assign head     = BufBase + NODE_W'(cur_bkt);
   assign cnt_addr = (func_ff == FUNC_GET) ? node_idx : slot_idx;
   assign cnt_cur  = cnt_arr_ff[cnt_addr];
   assign slot_bad = (32'(slot_ff) >= 32'(NumBuffers));
   assign slot_bkt = (32'(own_arr_ff[slot_idx]) >= 32'(NumBuckets)) ? '0
                                                                     : own_arr_ff[slot_idx];

   // four bits of the bucket hash per cycle
   assign mod_next = mod_tab[{id_ff, shreg_ff[BLOCK_W-1 -: 4]}];

   // status toward the controller
   always_comb begin
      stat.mod_last   = &bitcnt_ff;
      stat.walk_end   = (node == head) || (node >= BufBase) || (steps_ff >= BufBase);
      stat.match      = (dev_arr_ff[node_idx] == dev_ff) && (blk_arr_ff[node_idx] == blk_ff);
      stat.cnt_zero   = (cnt_cur == '0);
      stat.own_phase  = own_ff;
      stat.scan_done  = (fb_ff >= FB_W'(NumBuckets));
      stat.scan_is_id = (fb_ff[BKT_W-1:0] == id_ff);
      stat.relink     = (func_ff == FUNC_RELEASE) && !slot_bad && (cnt_cur == CNT_W'(1));
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // link read and write ports
   logic              next_re, prev_re, next_we, prev_we;
   logic [NODE_W-1:0] next_ra, prev_ra, next_wa, prev_wa, next_wd, prev_wd;

   always_comb begin
      next_re = 1'b0;
      prev_re = 1'b0;
      next_ra = node;
      prev_ra = node;
      next_we = 1'b0;
      prev_we = 1'b0;
      next_wa = tgt_ff;
      prev_wa = tgt_ff;
      next_wd = tgt_ff;
      prev_wd = tgt_ff;
      case (cmd.op)
         OP_WALK_HEAD: begin
            next_re = 1'b1;
            next_ra = BufBase + NODE_W'(id_ff);
         end
         OP_WALK_NEXT: next_re = 1'b1;
         OP_FREE_HEAD: begin
            prev_re = 1'b1;
            prev_ra = BufBase + NODE_W'(fb_ff[BKT_W-1:0]);
         end
         OP_FREE_PREV: prev_re = 1'b1;
         OP_DET_RD: begin
            next_re = 1'b1;
            prev_re = 1'b1;
            next_ra = tgt_ff;
            prev_ra = tgt_ff;
         end
         OP_DET_WR: begin
            next_we = (32'(prev_rd) < 32'(NodeCount));
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = (32'(next_rd) < 32'(NodeCount));
            prev_wa = next_rd;
            prev_wd = prev_rd;
         end
         OP_PUSH_RD: begin
            next_re = 1'b1;
            next_ra = BufBase + NODE_W'(dst_ff);
         end
         OP_PUSH_WR1: begin
            next_we = 1'b1;
            next_wa = tgt_ff;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = tgt_ff;
            prev_wd = BufBase + NODE_W'(dst_ff);
         end
         OP_PUSH_WR2: begin
            next_we = 1'b1;
            next_wa = BufBase + NODE_W'(dst_ff);
            next_wd = tgt_ff;
            prev_we = (32'(first_ff) < 32'(NodeCount));
            prev_wa = first_ff;
            prev_wd = tgt_ff;
         end
         default: begin
         end
      endcase
   end

   // link memories
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (next_re) begin
         next_q_ff <= next_mem[next_ra];
         next_v_ff <= nv_ff[next_ra];
         next_a_ff <= next_ra;
      end
      if (prev_re) begin
         prev_q_ff <= prev_mem[prev_ra];
         prev_v_ff <= pv_ff[prev_ra];
         prev_a_ff <= prev_ra;
      end
   end

   // link written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NodeCount; i++) begin
            nv_ff[i] <= 1'b0;
            pv_ff[i] <= 1'b0;
         end
      end else begin
         if (next_we) nv_ff[next_wa] <= 1'b1;
         if (prev_we) pv_ff[prev_wa] <= 1'b1;
      end
   end

   // per-buffer tags, counts and owners
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumBuffers; i++) begin
            dev_arr_ff[i] <= '0;
            blk_arr_ff[i] <= '0;
            val_arr_ff[i] <= 1'b0;
            cnt_arr_ff[i] <= '0;
            own_arr_ff[i] <= own_init[i];
         end
      end else begin
         case (cmd.op)
            OP_HIT: begin
               if (cnt_cur != CntMax) cnt_arr_ff[node_idx] <= cnt_cur + CNT_W'(1);
               val_arr_ff[node_idx] <= 1'b1;
            end
            OP_FILL_OWN, OP_FILL_STEAL: begin
               dev_arr_ff[node_idx] <= dev_ff;
               blk_arr_ff[node_idx] <= blk_ff;
               val_arr_ff[node_idx] <= 1'b1;
               cnt_arr_ff[node_idx] <= CNT_W'(1);
               if (cmd.op == OP_FILL_STEAL) own_arr_ff[node_idx] <= id_ff;
            end
            OP_SLOT: begin
               if (!slot_bad) begin
                  if (func_ff == FUNC_PIN) begin
                     if (cnt_cur != CntMax) cnt_arr_ff[slot_idx] <= cnt_cur + CNT_W'(1);
                  end else if (cnt_cur != '0) begin
                     cnt_arr_ff[slot_idx] <= cnt_cur - CNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // request capture, hash, walk and relink registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            func_ff   <= func_type'(req_func);
            dev_ff    <= req_device;
            blk_ff    <= req_block_number;
            slot_ff   <= req_buffer_slot;
            shreg_ff  <= req_block_number;
            bitcnt_ff <= '0;
            id_ff     <= '0;
         end
         OP_MOD: begin
            id_ff     <= mod_next;
            shreg_ff  <= {shreg_ff[BLOCK_W-5:0], 4'h0};
            bitcnt_ff <= bitcnt_ff + BITCNT_W'(1);
         end
         OP_WALK_HEAD: begin
            dir_ff   <= 1'b0;
            steps_ff <= '0;
         end
         OP_FREE_HEAD: begin
            dir_ff   <= 1'b1;
            steps_ff <= '0;
         end
         OP_WALK_NEXT, OP_FREE_PREV: steps_ff <= steps_ff + NODE_W'(1);
         OP_OWN: begin
            fb_ff  <= FB_W'(id_ff);
            own_ff <= 1'b1;
         end
         OP_SCAN_INIT: begin
            fb_ff  <= '0;
            own_ff <= 1'b0;
         end
         OP_SCAN_NEXT: fb_ff <= fb_ff + FB_W'(1);
         OP_FILL_STEAL: begin
            tgt_ff <= node;
            dst_ff <= id_ff;
         end
         OP_SLOT: begin
            tgt_ff <= NODE_W'(slot_ff);
            dst_ff <= slot_bkt;
         end
         OP_PUSH_WR1: first_ff <= next_rd;
         default: begin
         end
      endcase
   end

   // pending result fields
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_HIT: begin
            res_slot_ff   <= SLOT_W'(node);
            res_hit_ff    <= 1'b1;
            res_nread_ff  <= !val_arr_ff[node_idx];
            res_status_ff <= STATUS_OK;
         end
         OP_FILL_OWN, OP_FILL_STEAL: begin
            res_slot_ff   <= SLOT_W'(node);
            res_hit_ff    <= 1'b0;
            res_nread_ff  <= 1'b1;
            res_status_ff <= STATUS_OK;
         end
         OP_NOFREE: begin
            res_slot_ff   <= '0;
            res_hit_ff    <= 1'b0;
            res_nread_ff  <= 1'b0;
            res_status_ff <= STATUS_NOFREE;
         end
         OP_SLOT: begin
            res_slot_ff   <= slot_ff;
            res_hit_ff    <= 1'b0;
            res_nread_ff  <= 1'b0;
            if (slot_bad || (func_ff != FUNC_PIN && cnt_cur == '0)) begin
               res_status_ff <= STATUS_BAD;
            end else begin
               res_status_ff <= STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_hit_ff    <= res_hit_ff;
         rsp_nread_ff  <= res_nread_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_needs_read   = rsp_nread_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/hashed_block_buffer_cache.sv]
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// block buffer cache with hashed buckets and per-bucket recency lists
// ----------------------------------------------------------------------------
// req channel carries one item: func (get, release, pin, unpin), device,
// block_number and buffer_slot; rsp returns one item per request with
// granted_slot, hit, needs_read and status. both use valid/stall.
// one item is in work at a time; req_stall is high from acceptance until
// the result has been moved into the output register.
// a get hashes the block number four bits per cycle, then walks the links of
// its bucket; on a miss it opens buckets and visits their links from the
// least recent end looking for an unreferenced buffer, its own bucket first,
// then the others in increasing order, and relinks a buffer stolen from
// another bucket to the head of its new bucket. a release that drops the
// count of its buffer to zero also relinks it to the head of its bucket.
// the link memories give one link per cycle and set the walk rate.
// reset empties all buffers, clears every count and rebuilds the lists;
// the next item is accepted right after reset.
// a stalled result holds in the output register; the next request is still
// accepted and runs up to the point where its result would be written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hashed_block_buffer_cache #(
   parameter int NumBuffers = hbc_pkg::DefNumBuffers,
   parameter int NumBuckets = hbc_pkg::DefNumBuckets
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hbc_pkg::FUNC_W-1:0]   req_func,
   input  logic [hbc_pkg::DEV_W-1:0]    req_device,
   input  logic [hbc_pkg::BLOCK_W-1:0]  req_block_number,
   input  logic [hbc_pkg::SLOT_W-1:0]   req_buffer_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hbc_pkg::SLOT_W-1:0]   rsp_granted_slot,
   output logic                         rsp_hit,
   output logic                         rsp_needs_read,
   output logic [hbc_pkg::STATUS_W-1:0] rsp_status
);
   import hbc_pkg::*;

   hbc_cmd_type  cmd;
   hbc_stat_type stat;

   // sequencer
   hbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic
   hbc_dp #(
      .NumBuffers (NumBuffers),
      .NumBuckets (NumBuckets)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_device       (req_device),
      .req_block_number (req_block_number),
      .req_buffer_slot  (req_buffer_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_hit          (rsp_hit),
      .rsp_needs_read   (rsp_needs_read),
      .rsp_status       (rsp_status)
   );

   // an accepted item blocks the request side on the next cycle
   `HBC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a hit is always a good get
   `HBC_ASSERT_IMPL(a_hit_ok, clock, reset, rsp_valid && rsp_hit, rsp_status == STATUS_OK)
   // a failed get grants nothing and needs no read
   `HBC_ASSERT_IMPL(a_nofree_clean, clock, reset, rsp_valid && rsp_status == STATUS_NOFREE, rsp_granted_slot == '0 && !rsp_needs_read && !rsp_hit)
   // a result is only written while the request side is busy
   `HBC_ASSERT_IMPL(a_emit_busy, clock, reset, cmd.op == OP_EMIT, req_stall)

endmodule

`default_nettype wire

[tb/cache_checker.sv]
// ----------------------------------------------------------------------------
// cache_checker
// predicts every cache result from the accepted requests and compares
// ----------------------------------------------------------------------------
// keeps its own copy of the buffers, counts and bucket lists, updates it on
// each accepted request and checks each accepted result field by field
// against the oldest predicted result
// ----------------------------------------------------------------------------
module cache_checker
   import hbc_pkg::*;
#(
   parameter int NBUF = 30,
   parameter int NBKT = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [DEV_W-1:0]    req_device,
   input  logic [BLOCK_W-1:0]  req_block_number,
   input  logic [SLOT_W-1:0]   req_buffer_slot,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [SLOT_W-1:0]   rsp_granted_slot,
   input  logic                rsp_hit,
   input  logic                rsp_needs_read,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  fail_count,
   output int                  pending_count
);
   localparam int NODES = NBUF + NBKT;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic                hit;
      logic                nread;
      logic [STATUS_W-1:0] status;
   } cache_result_type;

   logic [DEV_W-1:0]   buf_dev   [NBUF];
   logic [BLOCK_W-1:0] buf_blk   [NBUF];
   logic               buf_vld   [NBUF];
   logic [CNT_W-1:0]   buf_cnt   [NBUF];
   int                 buf_bkt   [NBUF];
   int                 nxt       [NODES];
   int                 prv       [NODES];
   cache_result_type   expected_results[$];

   assign pending_count = expected_results.size();

   // unlink a node from its list
   function automatic void unlink(int n);
      int p, q;
      p = prv[n];
      q = nxt[n];
      nxt[p] = q;
      prv[q] = p;
   endfunction

   // insert a buffer at the head of a bucket
   function automatic void link_head(int n, int bkt);
      int h, first;
      h = NBUF + bkt;
      first = nxt[h];
      nxt[n] = first;
      prv[n] = h;
      prv[first] = n;
      nxt[h] = n;
   endfunction

   // least recent unreferenced buffer of a bucket, NBUF if none
   function automatic int oldest_free(int bkt);
      int h, n, k;
      h = NBUF + bkt;
      n = prv[h];
      for (k = 0; k < NBUF && n != h && n < NBUF; k++) begin
         if (buf_cnt[n] == 0) return n;
         n = prv[n];
      end
      return NBUF;
   endfunction

   function automatic void clear_cache();
      int i;
      for (i = 0; i < NBUF; i++) begin
         buf_dev[i] = '0;
         buf_blk[i] = '0;
         buf_vld[i] = 1'b0;
         buf_cnt[i] = '0;
         buf_bkt[i] = i % NBKT;
      end
      for (i = 0; i < NBKT; i++) begin
         nxt[NBUF+i] = NBUF + i;
         prv[NBUF+i] = NBUF + i;
      end
      for (i = 0; i < NBUF; i++) link_head(i, buf_bkt[i]);
   endfunction

   // apply one request and return the result it should give
   function automatic cache_result_type serve_request(func_type f, logic [DEV_W-1:0] dev,
                                                      logic [BLOCK_W-1:0] blk,
                                                      logic [SLOT_W-1:0] slot);
      cache_result_type r;
      int id, h, n, k, found, i;
      r = '{slot: slot, hit: 1'b0, nread: 1'b0, status: STATUS_OK};
      if (f == FUNC_GET) begin
         id = int'(blk % NBKT);
         h = NBUF + id;
         n = nxt[h];
         found = NBUF;
         for (k = 0; k < NBUF && n != h && n < NBUF; k++) begin
            if (buf_dev[n] == dev && buf_blk[n] == blk) begin
               found = n;
               break;
            end
            n = nxt[n];
         end
         if (found < NBUF) begin
            r.hit = 1'b1;
            if (buf_cnt[found] != CntMax) buf_cnt[found]++;
         end else begin
            found = oldest_free(id);
            if (found >= NBUF) begin
               // steal from the other buckets in increasing order
               for (i = 0; i < NBKT; i++) begin
                  if (i == id) continue;
                  found = oldest_free(i);
                  if (found < NBUF) begin
                     unlink(found);
                     buf_bkt[found] = id;
                     link_head(found, id);
                     break;
                  end
               end
            end
            if (found < NBUF) begin
               buf_dev[found] = dev;
               buf_blk[found] = blk;
               buf_vld[found] = 1'b0;
               buf_cnt[found] = 1;
            end
         end
         if (found < NBUF) begin
            r.slot = found[SLOT_W-1:0];
            r.nread = !buf_vld[found];
            buf_vld[found] = 1'b1;
         end else begin
            r.slot = '0;
            r.status = STATUS_NOFREE;
         end
      end else if (slot >= NBUF) begin
         r.status = STATUS_BAD;
      end else if (f == FUNC_PIN) begin
         if (buf_cnt[slot] != CntMax) buf_cnt[slot]++;
      end else if (buf_cnt[slot] == 0) begin
         r.status = STATUS_BAD;
      end else begin
         buf_cnt[slot]--;
         if (f == FUNC_RELEASE && buf_cnt[slot] == 0) begin
            unlink(slot);
            link_head(slot, buf_bkt[slot]);
         end
      end
      return r;
   endfunction

   initial fail_count = 0;

   // predict on request, compare on result
   always @(posedge clock) begin
      cache_result_type want;
      if (reset) begin
         clear_cache();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(serve_request(func_type'(req_func), req_device,
                                                     req_block_number, req_buffer_slot));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item, slot %0d", rsp_granted_slot);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_granted_slot !== want.slot) begin
                  $error("granted_slot expected %0d actual %0d", want.slot, rsp_granted_slot);
                  fail_count++;
               end
               if (rsp_hit !== want.hit) begin
                  $error("hit expected %0d actual %0d", want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_needs_read !== want.nread) begin
                  $error("needs_read expected %0d actual %0d", want.nread, rsp_needs_read);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the hashed block buffer cache
// ----------------------------------------------------------------------------
// directed gets, releases, pins and unpins cover stale matches, saturation,
// exhaustion, bad slots and underflow; then random traffic over a small block
// set with random gaps and result stalls; cache_checker does the checking
// ----------------------------------------------------------------------------
module tb;
   import hbc_pkg::*;

   localparam int NBUF = DefNumBuffers;
   localparam int NBKT = DefNumBuckets;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [DEV_W-1:0]    req_device;
   logic [BLOCK_W-1:0]  req_block_number;
   logic [SLOT_W-1:0]   req_buffer_slot;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SLOT_W-1:0]   rsp_granted_slot;
   logic                rsp_hit;
   logic                rsp_needs_read;
   logic [STATUS_W-1:0] rsp_status;
   int                  fail_count;
   int                  pending_count;
   logic                rsp_quiet;

   hashed_block_buffer_cache u_top (.*);

   cache_checker #(.NBUF(NBUF), .NBKT(NBKT)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side stalls at random
   initial begin
      int w;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_quiet || $urandom_range(3) == 0) w = 0;
         else w = $urandom_range(15);
         if (w != 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // send one item after a random gap, valid stays up for a follow-on item
   task automatic send_item(func_type f, logic [DEV_W-1:0] dev, logic [BLOCK_W-1:0] blk,
                            logic [SLOT_W-1:0] slot, bit gap);
      int w;
      w = gap ? $urandom_range(15) : 0;
      if ($urandom_range(3) == 0) w = 0;
      if (w != 0) begin
         req_valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_device <= dev;
      req_block_number <= blk;
      req_buffer_slot <= slot;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int i, k, s;
      logic [BLOCK_W-1:0] blk;
      rsp_quiet = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_GET;
      req_device = '0;
      req_block_number = '0;
      req_buffer_slot = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // stale match on device 0 block 0, then extremes of the fields
      send_item(FUNC_GET, 8'd0, 32'd0, 5'd0, 0);
      send_item(FUNC_GET, 8'hff, 32'hffff_ffff, 5'd31, 0);
      send_item(FUNC_GET, 8'hff, 32'hffff_ffff, 5'd0, 0);
      send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd31, 0);
      send_item(FUNC_PIN, 8'd0, 32'd0, 5'd30, 0);
      send_item(FUNC_UNPIN, 8'd0, 32'd0, 5'd29, 0);
      send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'd29, 0);
      // pin to saturation, then unpin a few
      for (i = 0; i < 256; i++) send_item(FUNC_PIN, 8'd0, 32'd0, 5'd5, 0);
      send_item(FUNC_GET, 8'd0, 32'd0, 5'd0, 0);
      for (i = 0; i < 3; i++) send_item(FUNC_UNPIN, 8'd0, 32'd0, 5'd5, 0);
      drain();

      // exhaust every free buffer with some failing gets, then release each slot once
      for (i = 0; i < NBUF + 1; i++)
         send_item(FUNC_GET, 8'd7, 32'(100 + i), 5'd0, 0);
      drain();
      for (s = 0; s < NBUF; s++)
         send_item(FUNC_RELEASE, 8'd0, 32'd0, 5'(s), 0);
      drain();
      rsp_quiet = 1'b0;

      // random traffic over a small block set so hits and steals are common
      for (k = 0; k < 220; k++) begin
         if (k == 110) begin
            drain();
            rsp_quiet = 1'b1;
            repeat (50) send_item(FUNC_GET, 8'($urandom_range(1)), 32'($urandom_range(40)),
                                  5'd0, 0);
            rsp_quiet = 1'b0;
         end
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               if ($urandom_range(15) == 0) blk = $urandom;
               else blk = 32'($urandom_range(60));
               send_item(FUNC_GET, 8'($urandom_range(3)) | ($urandom_range(15) == 0 ?
                         8'($urandom) : 8'd0), blk, 5'($urandom), 1);
            end
            4, 5, 6: send_item(FUNC_RELEASE, '0, '0, 5'($urandom_range(31)), 1);
            7: send_item(FUNC_PIN, 8'($urandom), $urandom, 5'($urandom_range(31)), 1);
            default: send_item(FUNC_UNPIN, '0, '0, 5'($urandom_range(31)), 1);
         endcase
         if ($urandom_range(40) == 0) drain();
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
